// ----- sv/dil_pkg.sv -----
package dil_pkg;

  localparam int CMD_W       = 2;
  localparam int VALUE_W     = 32;
  localparam int DOC_INDEX_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

endpackage

// ----- sv/dil_cell.sv -----
// One level of the search: owns every stored end whose index has exactly
// BIT trailing one bits, and decides index bit BIT for the query passing by.
module dil_cell #(
  parameter int L   = 11,
  parameter int PW  = 32,
  parameter int KW  = 32,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [KW-1:0] in_pos,
  input  logic [L-1:0]  in_idx,
  input  logic [L-1:0]  in_count,
  input  logic          wr_en,
  input  logic [L-1:0]  wr_index,
  input  logic [PW-1:0] wr_data,
  output logic          out_valid,
  output logic [KW-1:0] out_pos,
  output logic [L-1:0]  out_idx,
  output logic [L-1:0]  out_count
);

  localparam int DEPTH = 1 << (L - 1 - BIT);
  localparam int AW    = (L - 1 - BIT > 0) ? (L - 1 - BIT) : 1;
  localparam logic [L-1:0] LOW_ONES = L'((64'd1 << BIT) - 64'd1);
  localparam logic [L-1:0] LOW_MASK = L'((64'd1 << (BIT + 1)) - 64'd1);
  localparam logic [L-1:0] BIT_SEL  = L'(64'd1 << BIT);

  logic [PW-1:0] mem [DEPTH];
  logic [PW-1:0] rd_data;
  logic          valid;
  logic [KW-1:0] pos;
  logic [L-1:0]  idx;
  logic [L-1:0]  count;

  logic [L-1:0]  wr_shift;
  logic [L-1:0]  rd_shift;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          wr_hit;
  logic [L-1:0]  probe;
  logic          less;

  assign wr_shift = wr_index >> (BIT + 1);
  assign rd_shift = in_idx >> (BIT + 1);
  assign wr_addr  = wr_shift[AW-1:0];
  assign rd_addr  = rd_shift[AW-1:0];
  assign wr_hit   = wr_en && ((wr_index & LOW_MASK) == LOW_ONES);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
    pos   <= in_pos;
    idx   <= in_idx;
    count <= in_count;
  end

  // probes past the stored count act as +infinity
  assign probe = idx | LOW_ONES;
  assign less  = (probe < count) && (KW'(rd_data) < pos);

  assign out_valid = valid;
  assign out_pos   = pos;
  assign out_idx   = less ? (idx | BIT_SEL) : idx;
  assign out_count = count;

endmodule

// ----- sv/document_index_lookup.sv -----
// Document index lookup.
// Input channel (in_valid / in_stall, fields command and value) takes one
// beat per command: clear empties the table, append adds a sequence length
// (end = previous end + 1 + length, saturating at 2^POS_WIDTH - 1; the first
// end is the length itself; appends past MAX_SEQUENCES are dropped), lookup
// searches for the first stored end >= value.
// Output channel (out_valid / out_stall) carries one beat per lookup:
// doc_index and past_end (set when no stored end qualifies).
// The search runs down a chain of L = clog2(MAX_SEQUENCES + 1) cells, one
// cell per index bit, MSB first; each cell keeps its own slice of the end
// table in a local RAM and makes one probe per lookup. A lookup passes the
// issue register and the register of each cell into the output register,
// and no new beat is taken while it is in the chain. Clear and append can
// arrive back to back while no lookup is in the chain and the skid
// register is empty.
// A result held by out_stall sits in the output register; one more lookup
// may run meanwhile and parks its result in a skid register.
// Reset empties the table (count and running end to zero) and drops any
// pending results; the table RAMs are not cleared, no sweep is needed.
module document_index_lookup #(
  parameter int MAX_SEQUENCES = 1024,
  parameter int POS_WIDTH     = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dil_pkg::CMD_W-1:0]       command,
  input  logic [dil_pkg::VALUE_W-1:0]     value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dil_pkg::DOC_INDEX_W-1:0] doc_index,
  output logic                            past_end
);

  localparam int L  = $clog2(MAX_SEQUENCES + 1);
  localparam int KW = (POS_WIDTH > dil_pkg::VALUE_W) ? POS_WIDTH : dil_pkg::VALUE_W;
  localparam int SW = KW + 2;
  localparam logic [L-1:0]         FULL    = L'(MAX_SEQUENCES);
  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  // chain stages: stage 0 is the issue register, stage s+1 leaves cell s
  logic [L:0]    st_valid;
  logic [KW-1:0] st_pos   [L+1];
  logic [L-1:0]  st_idx   [L+1];
  logic [L-1:0]  st_count [L+1];

  logic                 issue_valid;
  logic [KW-1:0]        issue_pos;
  logic [L-1:0]         issue_count;

  logic [L-1:0]         count;
  logic [POS_WIDTH-1:0] running_end;

  logic                 skid_valid;
  logic [L-1:0]         skid_idx;
  logic                 skid_past;
  logic [L-1:0]         res_idx;
  logic                 res_past;

  logic                 accept;
  logic                 out_take;
  dil_pkg::cmd_t        cmd;
  logic                 wr_en;
  logic [SW-1:0]        sum;
  logic [POS_WIDTH-1:0] new_end;
  logic [L-1:0]         out_idx;
  logic                 out_past;

  assign cmd      = dil_pkg::cmd_t'(command);
  assign in_stall = (|st_valid) | skid_valid;
  assign accept   = in_valid & ~in_stall;
  assign out_take = out_valid & ~out_stall;

  // saturating end position for an append
  assign sum     = SW'(running_end) + SW'(count != '0) + SW'(value);
  assign new_end = (sum > SW'(POS_MAX)) ? POS_MAX : POS_WIDTH'(sum);
  assign wr_en   = accept && (cmd == dil_pkg::CMD_APPEND) && (count != FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_end <= '0;
    end else if (accept) begin
      if (cmd == dil_pkg::CMD_CLEAR) begin
        count       <= '0;
        running_end <= '0;
      end else if (wr_en) begin
        count       <= count + L'(1);
        running_end <= new_end;
      end
    end
  end

  // issue register
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_valid <= 1'b0;
    end else begin
      issue_valid <= accept && (cmd == dil_pkg::CMD_LOOKUP);
    end
    issue_pos   <= KW'(value);
    issue_count <= count;
  end

  assign st_valid[0] = issue_valid;
  assign st_pos[0]   = issue_pos;
  assign st_idx[0]   = '0;
  assign st_count[0] = issue_count;

  for (genvar s = 0; s < L; s++) begin : g_cell
    dil_cell #(
      .L   (L),
      .PW  (POS_WIDTH),
      .KW  (KW),
      .BIT (L - 1 - s)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[s]),
      .in_pos    (st_pos[s]),
      .in_idx    (st_idx[s]),
      .in_count  (st_count[s]),
      .wr_en     (wr_en),
      .wr_index  (count),
      .wr_data   (new_end),
      .out_valid (st_valid[s+1]),
      .out_pos   (st_pos[s+1]),
      .out_idx   (st_idx[s+1]),
      .out_count (st_count[s+1])
    );
  end

  assign res_idx  = st_idx[L];
  assign res_past = (st_idx[L] == st_count[L]);

  // output register plus skid; skid only fills when a result lands on a
  // stalled output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (st_valid[L]) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
        out_idx   <= res_idx;
        out_past  <= res_past;
      end else begin
        skid_valid <= 1'b1;
        skid_idx   <= res_idx;
        skid_past  <= res_past;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        out_idx    <= skid_idx;
        out_past   <= skid_past;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign doc_index = dil_pkg::DOC_INDEX_W'(out_idx);
  assign past_end  = out_past;

endmodule
